FILE: src/aatsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aatsp_pkg
// Types, constants and helpers shared by the ASCII angle to servo pulse unit.
// ----------------------------------------------------------------------------
package aatsp_pkg;

	localparam int LINE_BYTES_DEF  = 32;
	localparam int CMD_QUEUE_DEPTH = 2;

	localparam logic [7:0]  ANGLE_MAX      = 8'd180;
	localparam logic [7:0]  RECENTER_RESET = 8'd90;
	localparam logic [10:0] PULSE_BASE_US  = 11'd1000;

	// 1000/180 reduces to 50/9; the divide by 9 is a multiply by ceil(2^16/9),
	// exact for products up to 9000
	localparam logic [5:0]  DEG_SCALE  = 6'd50;
	localparam logic [12:0] DIV9_RECIP = 13'd7282;
	localparam int          DIV9_SHIFT = 16;

	localparam logic [7:0] CHR_CR    = 8'h0D;
	localparam logic [7:0] CHR_LF    = 8'h0A;
	localparam logic [7:0] CHR_SP    = 8'h20;
	localparam logic [7:0] CHR_TAB   = 8'h09;
	localparam logic [7:0] CHR_VT    = 8'h0B;
	localparam logic [7:0] CHR_FF    = 8'h0C;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_MINUS = 8'h2D;
	localparam logic [7:0] CHR_0     = 8'h30;
	localparam logic [7:0] CHR_9     = 8'h39;

	localparam logic OP_BYTE     = 1'b0;
	localparam logic OP_RECENTER = 1'b1;

	typedef enum logic {
		CMD_LINE,
		CMD_RECENTER
	} cmd_kind_t;

	typedef struct packed {
		logic       opcode;
		logic       channel;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic        out_channel;
		logic [10:0] pulse_us;
		logic        last;
	} out_item_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic       channel;
		logic [7:0] angle;
	} cmd_t;

	function automatic logic [7:0] clamp_angle(input logic [7:0] a);
		return (a > ANGLE_MAX) ? ANGLE_MAX : a;
	endfunction

endpackage

FILE: src/aatsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aatsp_front
// Takes input items, runs the per-channel line parsers and issues a command
// for every non-empty line end and every recenter event.
// ----------------------------------------------------------------------------
module aatsp_front #(
	parameter int LINE_BYTES = aatsp_pkg::LINE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  aatsp_pkg::in_item_t item,
	input  logic                cfg_we,
	input  logic [7:0]          cfg_wdata,
	output logic                cmd_push,
	output aatsp_pkg::cmd_t     cmd,
	input  logic                q_full
);
	import aatsp_pkg::*;

	localparam int CW = $clog2(LINE_BYTES);

	typedef enum logic [1:0] {
		PH_BLANK,
		PH_SIGN,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	logic [7:0]    accum_q [2];
	logic          neg_q   [2];
	phase_t        phase_q [2];
	logic [CW-1:0] count_q [2];
	logic [7:0]    recenter_q;

	logic          accept;
	logic          ch;
	logic [7:0]    b;
	logic          is_term, is_blank, is_sign, is_digit;
	logic [CW:0]   cnt_inc;
	logic          overflow;
	logic [11:0]   digit_acc;
	logic          gen;
	logic [7:0]    nx_accum;
	logic          nx_neg;
	phase_t        nx_phase;
	logic [CW-1:0] nx_count;

	assign full     = q_full;
	assign accept   = push && !q_full;
	assign ch       = item.channel;
	assign b        = item.rx_byte;
	assign is_term  = (b == CHR_CR) || (b == CHR_LF);
	assign is_blank = (b == CHR_SP) || (b == CHR_TAB) || (b == CHR_VT) || (b == CHR_FF);
	assign is_sign  = (b == CHR_PLUS) || (b == CHR_MINUS);
	assign is_digit = (b >= CHR_0) && (b <= CHR_9);
	assign cnt_inc  = {1'b0, count_q[ch]} + (CW+1)'(1);
	assign overflow = (cnt_inc == (CW+1)'(LINE_BYTES));
	assign digit_acc = 12'(accum_q[ch]) * 12'd10 + 12'(b[3:0]);
	assign cmd_push = accept && gen;

	always_comb begin
		gen         = 1'b0;
		cmd.kind    = CMD_LINE;
		cmd.channel = ch;
		cmd.angle   = neg_q[ch] ? 8'd0 : clamp_angle(accum_q[ch]);
		nx_accum    = accum_q[ch];
		nx_neg      = neg_q[ch];
		nx_phase    = phase_q[ch];
		nx_count    = count_q[ch];
		if (item.opcode == OP_RECENTER) begin
			gen         = 1'b1;
			cmd.kind    = CMD_RECENTER;
			cmd.channel = 1'b0;
			cmd.angle   = clamp_angle(recenter_q);
		end else if (is_term || overflow) begin
			gen      = is_term && (count_q[ch] != '0);
			nx_accum = '0;
			nx_neg   = 1'b0;
			nx_phase = PH_BLANK;
			nx_count = '0;
		end else begin
			nx_count = cnt_inc[CW-1:0];
			if (phase_q[ch] == PH_BLANK && is_blank) begin
				nx_phase = PH_BLANK;
			end else if (phase_q[ch] == PH_BLANK && is_sign) begin
				nx_neg   = (b == CHR_MINUS);
				nx_phase = PH_SIGN;
			end else if (phase_q[ch] == PH_DONE) begin
				nx_phase = PH_DONE;
			end else if (is_digit) begin
				nx_accum = (digit_acc > 12'd255) ? 8'd255 : digit_acc[7:0];
				nx_phase = PH_DIGITS;
			end else begin
				nx_phase = PH_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recenter_q <= RECENTER_RESET;
			for (int i = 0; i < 2; i++) begin
				accum_q[i] <= '0;
				neg_q[i]   <= 1'b0;
				phase_q[i] <= PH_BLANK;
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				recenter_q <= cfg_wdata;
			end
			if (accept && item.opcode == OP_BYTE) begin
				accum_q[ch] <= nx_accum;
				neg_q[ch]   <= nx_neg;
				phase_q[ch] <= nx_phase;
				count_q[ch] <= nx_count;
			end
		end
	end

endmodule

FILE: src/aatsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aatsp_queue
// Small register queue of commands between the parser and the pulse stage.
// ----------------------------------------------------------------------------
module aatsp_queue #(
	parameter int DEPTH = aatsp_pkg::CMD_QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  aatsp_pkg::cmd_t wdata,
	output logic            full,
	input  logic            pop,
	output aatsp_pkg::cmd_t rdata,
	output logic            empty
);
	import aatsp_pkg::*;

	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_push, do_pop;

	assign full    = (cnt_q == CNTW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNTW'(1);
				2'b01:   cnt_q <= cnt_q - CNTW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: src/aatsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aatsp_back
// Expands commands into results and converts angles to pulse widths in a
// two-stage pipeline ending in the result register.
// ----------------------------------------------------------------------------
module aatsp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  aatsp_pkg::cmd_t      head,
	input  logic                 q_empty,
	output logic                 q_pop,
	output aatsp_pkg::out_item_t result,
	output logic                 empty,
	input  logic                 pop
);
	import aatsp_pkg::*;

	logic        sub_q;
	logic        valid_s1, ch_s1, last_s1;
	logic [13:0] prod_s1;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        out_free, move, s1_free, load, is_rc;
	logic [26:0] quot_full;

	assign out_free  = !out_valid_q || pop;
	assign move      = valid_s1 && out_free;
	assign s1_free   = !valid_s1 || move;
	assign load      = s1_free && !q_empty;
	assign is_rc     = (head.kind == CMD_RECENTER);
	assign q_pop     = load && (!is_rc || sub_q);
	assign quot_full = 27'(prod_s1) * 27'(DIV9_RECIP);
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk) begin
		if (load) begin
			ch_s1   <= is_rc ? sub_q : head.channel;
			last_s1 <= is_rc ? sub_q : 1'b1;
			prod_s1 <= 14'(head.angle) * 14'(DEG_SCALE);
		end
		if (move) begin
			out_q.out_channel <= ch_s1;
			out_q.last        <= last_s1;
			out_q.pulse_us    <= PULSE_BASE_US + quot_full[DIV9_SHIFT +: 11];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q       <= 1'b0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load && is_rc) begin
				sub_q <= !sub_q;
			end
			if (s1_free) begin
				valid_s1 <= load;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

endmodule

FILE: src/ascii_angle_to_servo_pulse_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_angle_to_servo_pulse_unit
// Two-channel ASCII angle line parser producing servo pulse widths.
// ----------------------------------------------------------------------------
// One input item is taken every cycle while full is low. A non-empty line
// end or a recenter event becomes a command in a two-entry queue; the pulse
// stage turns each command into results at one result per cycle while the
// result register is free or popped. A line end's command passes through
// the queue, the first pipeline stage and the result register, and a
// recenter event uses two result slots. The angle-to-pulse pipeline has
// two stages: multiply by 50, then divide by 9 by reciprocal.
module ascii_angle_to_servo_pulse_unit #(
	parameter int LINE_BYTES = aatsp_pkg::LINE_BYTES_DEF,
	parameter int QUEUE_DEPTH = aatsp_pkg::CMD_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  aatsp_pkg::in_item_t  item,
	output logic                 empty,
	input  logic                 pop,
	output aatsp_pkg::out_item_t result,
	input  logic                 cfg_we,
	input  logic [7:0]           cfg_wdata
);
	import aatsp_pkg::*;

	logic cmd_push, q_full, q_empty, q_pop;
	cmd_t cmd, head;

	aatsp_front #(
		.LINE_BYTES(LINE_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_push (cmd_push),
		.cmd      (cmd),
		.q_full   (q_full)
	);

	aatsp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (head),
		.empty (q_empty)
	);

	aatsp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_full)
		else $error("command pushed into full queue");

	a_pulse_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result.pulse_us >= 11'd1000 && result.pulse_us <= 11'd2000))
		else $error("pulse width out of range");

	a_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !result.last) |-> (result.out_channel == 1'b0))
		else $error("non-final result not on channel 0");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !result.last) |=>
			(!empty && result.last && result.out_channel == 1'b1))
		else $error("recenter second result missing");
`endif

endmodule

FILE: sim/ascii_angle_to_servo_pulse_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_angle_to_servo_pulse_unit_test
// Self-checking bench for the two-channel ASCII angle to servo pulse unit.
// A queue-fed driver sends byte and recenter items and tracks the per-channel
// line parsers to predict every pulse result. A monitor pops results under
// random idling and a long hold-off, and compares each against the oldest
// prediction. The recenter angle is swept across its extremes between phases.
// ----------------------------------------------------------------------------
module ascii_angle_to_servo_pulse_unit_test;
	import aatsp_pkg::*;

	localparam int DRAIN_CYCLES   = 16;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT    = 2000;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_SIGN,
		PH_DIGITS,
		PH_DONE
	} parse_ph_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       push      = 1'b0;
	logic       full;
	in_item_t   item      = '0;
	logic       empty;
	logic       pop       = 1'b0;
	out_item_t  result;
	logic       cfg_we    = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;

	// stimulus and prediction
	in_item_t   feed_q [$];
	out_item_t  pulse_due_q [$];
	logic [7:0] line_tmp [$];
	logic [7:0] chars_h [$];
	logic [7:0] chars_v [$];
	int         in_flight = 0;
	int         mismatch_cnt = 0;
	int         tx_idle_pct = 29;
	int         rx_idle_pct = 29;
	int         rx_hold_req = 0;
	int         rx_hold_seen = 0;
	int         rx_hold_left = 0;
	int         quiet_cycles = 0;
	logic       nxt_push;
	in_item_t   nxt_item;
	out_item_t  want;

	// tracked parser state
	logic [7:0] recenter_deg = RECENTER_RESET;
	logic [7:0] mag_acc [2] = '{8'd0, 8'd0};
	logic       neg_seen [2] = '{1'b0, 1'b0};
	parse_ph_t  ph_st [2] = '{PH_LEAD, PH_LEAD};
	logic [5:0] line_len [2] = '{6'd0, 6'd0};

	ascii_angle_to_servo_pulse_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic logic [10:0] pulse_for_deg(input logic [7:0] deg);
		int unsigned d;
		d = (deg > ANGLE_MAX) ? 180 : deg;
		return 11'(1000 + (d * 1000) / 180);
	endfunction

	function automatic void clear_line(input logic ch);
		mag_acc[ch] = 8'd0;
		neg_seen[ch] = 1'b0;
		ph_st[ch] = PH_LEAD;
		line_len[ch] = 6'd0;
	endfunction

	task automatic predict_pulses(input in_item_t it);
		logic        ch;
		logic [7:0]  b;
		int unsigned v;
		out_item_t   r;
		ch = it.channel;
		b = it.rx_byte;
		if (it.opcode == OP_RECENTER) begin
			r.pulse_us = pulse_for_deg(recenter_deg);
			r.out_channel = 1'b0;
			r.last = 1'b0;
			pulse_due_q.push_back(r);
			r.out_channel = 1'b1;
			r.last = 1'b1;
			pulse_due_q.push_back(r);
			return;
		end
		if (b == CHR_CR || b == CHR_LF) begin
			if (line_len[ch] != 6'd0) begin
				r.out_channel = ch;
				r.pulse_us = pulse_for_deg(neg_seen[ch] ? 8'd0 : mag_acc[ch]);
				r.last = 1'b1;
				pulse_due_q.push_back(r);
			end
			clear_line(ch);
			return;
		end
		line_len[ch] = line_len[ch] + 6'd1;
		if (line_len[ch] >= LINE_BYTES_DEF) begin
			clear_line(ch);
			return;
		end
		if (ph_st[ch] == PH_LEAD) begin
			if (b == CHR_SP || b == CHR_TAB || b == CHR_VT || b == CHR_FF)
				return;
			if (b == CHR_PLUS || b == CHR_MINUS) begin
				neg_seen[ch] = (b == CHR_MINUS);
				ph_st[ch] = PH_SIGN;
				return;
			end
		end
		if (ph_st[ch] == PH_DONE)
			return;
		if (b >= CHR_0 && b <= CHR_9) begin
			v = mag_acc[ch] * 10 + (b - CHR_0);
			mag_acc[ch] = (v > 255) ? 8'd255 : 8'(v);
			ph_st[ch] = PH_DIGITS;
		end else begin
			ph_st[ch] = PH_DONE;
		end
	endtask

	task automatic report_error(input string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%s", msg);
	endtask

	task automatic add_item(input logic op, input logic ch, input logic [7:0] b);
		in_item_t it;
		it.opcode = op;
		it.channel = ch;
		it.rx_byte = b;
		feed_q.push_back(it);
	endtask

	task automatic add_text(input logic ch, input string s);
		for (int i = 0; i < s.len(); i++)
			add_item(OP_BYTE, ch, s[i]);
	endtask

	// one well-formed line: blanks, optional sign, digits, maybe junk, CR/LF/CRLF
	task automatic build_line();
		int    n;
		int    k;
		string s;
		line_tmp.delete();
		n = $urandom_range(0, 2);
		repeat (n) begin
			k = $urandom_range(0, 3);
			line_tmp.push_back(k == 0 ? CHR_SP : k == 1 ? CHR_TAB : k == 2 ? CHR_VT : CHR_FF);
		end
		k = $urandom_range(0, 3);
		if (k == 2)
			line_tmp.push_back(CHR_PLUS);
		else if (k == 3)
			line_tmp.push_back(CHR_MINUS);
		if ($urandom_range(0, 9) < 6) begin
			s = $sformatf("%0d", $urandom_range(0, 200));
		end else begin
			s = "";
			n = $urandom_range(1, 6);
			repeat (n)
				s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		end
		for (int i = 0; i < s.len(); i++)
			line_tmp.push_back(s[i]);
		if ($urandom_range(0, 9) == 0)
			line_tmp.push_back(8'($urandom_range(33, 126)));
		k = $urandom_range(0, 2);
		if (k != 1)
			line_tmp.push_back(CHR_CR);
		if (k != 0)
			line_tmp.push_back(CHR_LF);
	endtask

	task automatic gen_random(input int target);
		int         made;
		int         r;
		int         n;
		logic       ch;
		logic [7:0] b;
		made = 0;
		while (made < target) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				add_item(OP_RECENTER, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				made++;
			end else if (r < 12) begin
				n = $urandom_range(1, 6);
				repeat (n)
					add_item(OP_BYTE, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
				made += n;
			end else if (r < 16) begin
				// long line, around the overflow length
				ch = 1'($urandom_range(0, 1));
				n = $urandom_range(29, 40);
				repeat (n) begin
					b = 8'($urandom_range(0, 255));
					if (b == CHR_CR || b == CHR_LF)
						b = CHR_9;
					add_item(OP_BYTE, ch, b);
				end
				add_item(OP_BYTE, ch, $urandom_range(0, 1) ? CHR_CR : CHR_LF);
				made += n + 1;
			end else begin
				chars_h.delete();
				chars_v.delete();
				r = $urandom_range(0, 3);
				if (r != 1) begin
					build_line();
					chars_h = {chars_h, line_tmp};
				end
				if (r != 0) begin
					build_line();
					chars_v = {chars_v, line_tmp};
				end
				made += chars_h.size() + chars_v.size();
				while (chars_h.size() != 0 || chars_v.size() != 0) begin
					if (chars_v.size() == 0 || (chars_h.size() != 0 && $urandom_range(0, 1)))
						add_item(OP_BYTE, 1'b0, chars_h.pop_front());
					else
						add_item(OP_BYTE, 1'b1, chars_v.pop_front());
				end
			end
		end
	endtask

	task automatic wait_drained();
		while (feed_q.size() != 0 || in_flight != 0 || pulse_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_recenter(input logic [7:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		recenter_deg = v;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			nxt_push = push;
			nxt_item = item;
			if (push && !full) begin
				in_flight--;
				predict_pulses(item);
				nxt_push = 1'b0;
			end
			if (!nxt_push && feed_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				nxt_item = feed_q.pop_front();
				in_flight++;
				nxt_push = 1'b1;
			end
			push <= nxt_push;
			item <= nxt_item;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (pulse_due_q.size() == 0) begin
					report_error($sformatf("unexpected result: ch=%0d pulse=%0d last=%0d",
						result.out_channel, result.pulse_us, result.last));
				end else begin
					want = pulse_due_q.pop_front();
					if (result.out_channel !== want.out_channel)
						report_error($sformatf("out_channel: expected %0d, got %0d",
							want.out_channel, result.out_channel));
					if (result.pulse_us !== want.pulse_us)
						report_error($sformatf("pulse_us on ch %0d: expected %0d, got %0d",
							want.out_channel, want.pulse_us, result.pulse_us));
					if (result.last !== want.last)
						report_error($sformatf("last on ch %0d: expected %0d, got %0d",
							want.out_channel, want.last, result.last));
				end
			end
			if (rx_hold_seen != rx_hold_req) begin
				rx_hold_seen = rx_hold_req;
				rx_hold_left = RX_HOLD_CYCLES;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed, with the recenter angle at its reset value
		add_text(1'b0, "180");
		add_item(OP_BYTE, 1'b0, CHR_CR);
		add_text(1'b1, "+0");
		add_item(OP_BYTE, 1'b1, CHR_CR);
		add_item(OP_BYTE, 1'b1, CHR_LF);
		add_text(1'b0, " \t\v\f9");
		add_item(OP_BYTE, 1'b0, CHR_CR);
		add_text(1'b1, "-75");
		add_item(OP_BYTE, 1'b1, CHR_LF);
		add_text(1'b0, "999x");
		add_item(OP_BYTE, 1'b0, CHR_CR);
		add_item(OP_RECENTER, 1'b1, 8'hFF);
		wait_drained();

		write_recenter(8'd0);
		gen_random(130);
		wait_drained();

		// no idling on either side
		write_recenter(ANGLE_MAX);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		gen_random(150);
		wait_drained();

		// receiver holds off while the sender keeps offering
		write_recenter(8'd255);
		rx_idle_pct = 29;
		rx_hold_req++;
		gen_random(120);
		wait_drained();

		tx_idle_pct = 29;
		write_recenter(8'($urandom_range(1, 179)));
		gen_random(180);
		wait_drained();

		write_recenter(RECENTER_RESET);
		gen_random(170);
		wait_drained();

		if (mismatch_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
